// ----- design/gfms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfms_pkg
// shared types, constants and GF(2^8) helper functions for the multiply and
// s-box pipeline (polynomial x^8 + x^4 + x^3 + x + 1)
// ----------------------------------------------------------------------------
package gfms_pkg;

    localparam int BYTE_W = 8;
    localparam int CLMUL_W = 2 * BYTE_W - 1;

    localparam logic MODE_MUL = 1'b0;
    localparam logic MODE_SBOX = 1'b1;

    localparam logic [BYTE_W:0] POLY = 9'h11b;
    localparam logic [BYTE_W-1:0] AFFINE_CONST = 8'h63;

    typedef logic [BYTE_W-1:0] byte_table_t [256];
    typedef logic [BYTE_W-1:0] col_table_t [BYTE_W];

    localparam col_table_t AFFINE_COL = '{
        8'h1f, 8'h3e, 8'h7c, 8'hf8, 8'hf1, 8'he3, 8'hc7, 8'h8f
    };

    typedef struct packed {
        logic                 mode;
        logic [CLMUL_W-1:0]   clmul;
        logic [BYTE_W-1:0]    inv;
    } expand_t;

    // carry-less product, unreduced
    function automatic logic [CLMUL_W-1:0] clmul8(
        input logic [BYTE_W-1:0] x,
        input logic [BYTE_W-1:0] y
    );
        logic [CLMUL_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (x[k])
            begin
                acc = acc ^ (CLMUL_W'(y) << k);
            end
        end
        return acc;
    endfunction

    // fold bits 14..8 back in with the field polynomial
    function automatic logic [BYTE_W-1:0] gf_reduce(input logic [CLMUL_W-1:0] p);
        logic [CLMUL_W-1:0] acc;
        acc = p;
        for (int k = CLMUL_W - 1; k >= BYTE_W; k--)
        begin
            if (acc[k])
            begin
                acc = acc ^ (CLMUL_W'(POLY) << (k - BYTE_W));
            end
        end
        return acc[BYTE_W-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] gf_mul(
        input logic [BYTE_W-1:0] x,
        input logic [BYTE_W-1:0] y
    );
        return gf_reduce(clmul8(x, y));
    endfunction

    // x^254, which is zero for zero
    function automatic logic [BYTE_W-1:0] gf_inv(input logic [BYTE_W-1:0] x);
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] base;
        logic [BYTE_W-1:0] e;
        acc = 8'h01;
        base = x;
        e = 8'd254;
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (e[k])
            begin
                acc = gf_mul(acc, base);
            end
            base = gf_mul(base, base);
        end
        return acc;
    endfunction

    function automatic byte_table_t build_inv_table();
        byte_table_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = gf_inv(BYTE_W'(i));
        end
        return t;
    endfunction

    localparam byte_table_t INV_TABLE = build_inv_table();

    function automatic logic [BYTE_W-1:0] affine(input logic [BYTE_W-1:0] t);
        logic [BYTE_W-1:0] r;
        r = '0;
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (t[k])
            begin
                r = r ^ AFFINE_COL[k];
            end
        end
        return r ^ AFFINE_CONST;
    endfunction

endpackage

// ----- design/gfms_expand.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfms_expand
// first pipeline stage: carry-less product of the operands and inverse
// lookup of operand a
// ----------------------------------------------------------------------------
module gfms_expand
    import gfms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  logic              mode,
    input  logic [BYTE_W-1:0] operand_a,
    input  logic [BYTE_W-1:0] operand_b,
    output logic              dn_valid,
    input  logic              dn_ready,
    output expand_t           dn_data
);

    logic    valid_reg;
    expand_t data_reg;
    expand_t data_next;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        data_next.mode = mode;
        data_next.clmul = clmul8(operand_a, operand_b);
        data_next.inv = INV_TABLE[operand_a];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data = data_reg;

endmodule

// ----- design/gfms_finish.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfms_finish
// second pipeline stage: polynomial reduction of the product, affine map of
// the inverse, and selection by mode
// ----------------------------------------------------------------------------
module gfms_finish
    import gfms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  expand_t           up_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output logic [BYTE_W-1:0] dn_byte
);

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        case (up_data.mode)
            MODE_MUL:  byte_next = gf_reduce(up_data.clmul);
            MODE_SBOX: byte_next = affine(up_data.inv);
            default:   byte_next = gf_reduce(up_data.clmul);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            byte_reg <= byte_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_byte = byte_reg;

endmodule

// ----- design/gf256_multiply_and_sbox.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf256_multiply_and_sbox
// GF(2^8) multiplier (polynomial 0x11b) and AES forward s-box in one
// three-stage pipeline
//
// input channel: valid / ready with mode, operand_a, operand_b per beat
// output channel: result_valid / result_ready with result_byte per beat
// mode 0 returns operand_a * operand_b in the field, mode 1 returns the
// s-box of operand_a (operand_b unused)
// a beat accepted at an edge loads the expand stage, then moves through the
// finish stage to the output register, which drives result_valid
// throughput: one beat per cycle while result_ready is high; each stage holds one beat and moves on
// when the stage after it is empty or being drained
// reset clears all valid bits; no clearing pass, ready comes up at once
// when result_ready is low the pipeline fills up to three beats, then ready
// drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
module gf256_multiply_and_sbox
    import gfms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              ready,
    input  logic              mode,
    input  logic [BYTE_W-1:0] operand_a,
    input  logic [BYTE_W-1:0] operand_b,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [BYTE_W-1:0] result_byte
);

    logic              s1_valid;
    logic              s1_ready;
    expand_t           s1_data;
    logic              s2_valid;
    logic              s2_ready;
    logic [BYTE_W-1:0] s2_byte;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;

    gfms_expand u_expand (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (valid),
        .up_ready  (ready),
        .mode      (mode),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .dn_valid  (s1_valid),
        .dn_ready  (s1_ready),
        .dn_data   (s1_data)
    );

    gfms_finish u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_ready (s2_ready),
        .dn_byte  (s2_byte)
    );

    // output register
    assign s2_ready = !out_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            out_valid_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid && s2_ready)
        begin
            out_byte_reg <= s2_byte;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_byte = out_byte_reg;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks gf256_multiply_and_sbox against a behavioral model of GF(2^8)
// multiply and the AES forward s-box; a queue-fed driver and a monitor run
// under three idle profiles, with a full drain partway through
// ----------------------------------------------------------------------------
module tb;
    import gfms_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
    } beat_t;

    typedef struct packed {
        beat_t             src;
        logic [BYTE_W-1:0] value;
    } awaited_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              valid = 1'b0;
    logic              ready;
    logic              mode = MODE_MUL;
    logic [BYTE_W-1:0] operand_a = '0;
    logic [BYTE_W-1:0] operand_b = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic [BYTE_W-1:0] result_byte;

    beat_t    pending_beats[$];
    awaited_t awaited_results[$];
    awaited_t oldest;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       error_count = 0;
    int       cycle_count = 0;

    gf256_multiply_and_sbox u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (valid),
        .ready        (ready),
        .mode         (mode),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_byte  (result_byte)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [BYTE_W-1:0] field_product(
        input logic [BYTE_W-1:0] x,
        input logic [BYTE_W-1:0] y
    );
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] addend;
        acc = '0;
        addend = y;
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (x[k])
            begin
                acc = acc ^ addend;
            end
            addend = {addend[BYTE_W-2:0], 1'b0} ^ (addend[BYTE_W-1] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // x^254 by square and multiply; zero stays zero
    function automatic logic [BYTE_W-1:0] field_inverse(input logic [BYTE_W-1:0] x);
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] base;
        logic [BYTE_W-1:0] power;
        acc = 8'h01;
        base = x;
        power = 8'd254;
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (power[k])
            begin
                acc = field_product(acc, base);
            end
            base = field_product(base, base);
        end
        return acc;
    endfunction

    // affine step as the xor of the byte, its four left rotations and the constant
    function automatic logic [BYTE_W-1:0] substitute(input logic [BYTE_W-1:0] x);
        logic [BYTE_W-1:0] t;
        t = field_inverse(x);
        return t ^ {t[6:0], t[7]} ^ {t[5:0], t[7:6]} ^ {t[4:0], t[7:5]}
            ^ {t[3:0], t[7:4]} ^ AFFINE_CONST;
    endfunction

    function automatic logic [BYTE_W-1:0] unit_output(input beat_t in_beat);
        if (in_beat.mode == MODE_SBOX)
        begin
            return substitute(in_beat.a);
        end
        return field_product(in_beat.a, in_beat.b);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count = error_count + 1;
    endtask

    task automatic add_beat(input logic m, input logic [7:0] a, input logic [7:0] b);
        beat_t item;
        item.mode = m;
        item.a = a;
        item.b = b;
        pending_beats.push_back(item);
    endtask

    // corner bytes now and then, otherwise uniform
    function automatic logic [BYTE_W-1:0] random_operand();
        logic [BYTE_W-1:0] corners [4];
        corners[0] = 8'h00;
        corners[1] = 8'h01;
        corners[2] = 8'h80;
        corners[3] = 8'hff;
        if ($urandom_range(7) == 0)
        begin
            return corners[$urandom_range(3)];
        end
        return BYTE_W'($urandom_range(255));
    endfunction

    task automatic add_random_beats(input int count);
        for (int n = 0; n < count; n++)
        begin
            add_beat($urandom_range(1) ? MODE_SBOX : MODE_MUL,
                     random_operand(), random_operand());
        end
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || awaited_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (valid && ready)
            begin
                awaited_results.push_back(
                    '{src: '{mode: mode, a: operand_a, b: operand_b},
                      value: unit_output('{mode: mode, a: operand_a, b: operand_b})});
                void'(pending_beats.pop_front());
            end
            if (!valid || ready)
            begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    valid <= 1'b1;
                    mode <= pending_beats[0].mode;
                    operand_a <= pending_beats[0].a;
                    operand_b <= pending_beats[0].b;
                end
                else
                begin
                    valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch($sformatf("result 0x%02h with no beat outstanding",
                                          result_byte));
            end
            else
            begin
                oldest = awaited_results.pop_front();
                if (result_byte !== oldest.value)
                begin
                    report_mismatch($sformatf(
                        "mode %0d a 0x%02h b 0x%02h: got 0x%02h, want 0x%02h",
                        oldest.src.mode, oldest.src.a, oldest.src.b,
                        result_byte, oldest.value));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 18;
        recv_idle_pct = 63;

        // products at the extremes, reduction, a known inverse pair
        add_beat(MODE_MUL, 8'h00, 8'h00);
        add_beat(MODE_MUL, 8'hff, 8'hff);
        add_beat(MODE_MUL, 8'h01, 8'hff);
        add_beat(MODE_MUL, 8'hff, 8'h01);
        add_beat(MODE_MUL, 8'h80, 8'h02);
        add_beat(MODE_MUL, 8'h02, 8'h80);
        add_beat(MODE_MUL, 8'h53, 8'hca);
        add_beat(MODE_MUL, 8'h57, 8'h83);
        add_beat(MODE_MUL, 8'h55, 8'haa);
        add_beat(MODE_MUL, 8'haa, 8'h55);
        add_beat(MODE_MUL, 8'h00, 8'hff);
        // s-box, zero input and ignored second operand
        add_beat(MODE_SBOX, 8'h00, 8'h00);
        add_beat(MODE_SBOX, 8'h00, 8'hff);
        add_beat(MODE_SBOX, 8'h01, 8'h00);
        add_beat(MODE_SBOX, 8'hff, 8'h00);
        add_beat(MODE_SBOX, 8'h53, 8'haa);
        add_beat(MODE_SBOX, 8'h80, 8'h55);
        add_beat(MODE_SBOX, 8'h55, 8'hff);
        add_beat(MODE_SBOX, 8'haa, 8'h01);

        add_random_beats(300);
        // sender holds off until everything has come back
        wait_drained();
        add_random_beats(350);
        wait_drained();

        send_idle_pct = 63;
        recv_idle_pct = 18;
        add_random_beats(650);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_beats(630);
        wait_drained();

        repeat (10) @(negedge clk);
        if (awaited_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived",
                                      awaited_results.size()));
        end
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
